// ===== rtl/core/mfce_pkg.sv =====
// ----------------------------------------------------------------------------
// mfce_pkg
// Shared types, constants and the CRC-16 byte update for the frame checker.
// ----------------------------------------------------------------------------
package mfce_pkg;

    localparam int WORD_COUNT_DEF  = 8;
    localparam int MAX_OUT         = 8;
    localparam int FIRST_WORD_BYTE = 3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0]  FRAME_LENGTH_RST = 8'd42;
    localparam logic [15:0] VALUE_OFFSET_RST = 16'd30000;
    localparam logic [7:0]  COUNT_MAX        = 8'd255;

    // Register indexes on the configuration port (paddr[2]).
    localparam logic REG_FRAME_LENGTH = 1'b0;
    localparam logic REG_VALUE_OFFSET = 1'b1;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_LEN = 2'd1,
        ST_CRC = 2'd2
    } t_status;

    // Frame-end event handed from the frame unit to the result unit.
    typedef struct packed {
        logic    load;
        t_status status;
    } t_done;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/modbus_frame_crc_value_extractor_top.sv =====
// A frame-end byte goes through the input register and then loads the result register, which shows its first result.
// Throughput: one byte per cycle while the input is not stalled; results leave at one per cycle when not stalled.
// A frame end waits in the input register until the previous frame's results
// are all gone, so a valid frame's words (up to eight) bound how fast frame ends pass.
// Reset (synchronous, active low) clears the frame state, the result queue and
// the configuration registers to their defaults; stored words are not cleared.
// ----------------------------------------------------------------------------
// modbus_frame_crc_value_extractor_top
// MODBUS RTU frame checker with CRC-16 and big-endian word extraction.
// ----------------------------------------------------------------------------
module modbus_frame_crc_value_extractor_top
    import mfce_pkg::*;
#(
    parameter int WORD_COUNT = WORD_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_frame,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_word_value,
    output logic [2:0]  o_word_index,
    output logic [1:0]  o_frame_status,
    output logic        o_last_result
);

    localparam int NRES = (WORD_COUNT < MAX_OUT) ? WORD_COUNT : MAX_OUT;

    logic [7:0]            r_frame_length;
    logic [15:0]           r_value_offset;
    logic                  wr_en;
    t_done                 done;
    logic                  res_free;
    logic [NRES-1:0][15:0] words;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= FRAME_LENGTH_RST;
            r_value_offset <= VALUE_OFFSET_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_FRAME_LENGTH) begin
                r_frame_length <= pwdata[7:0];
            end else begin
                r_value_offset <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_VALUE_OFFSET) begin
            prdata = {16'h0000, r_value_offset};
        end else begin
            prdata = {24'h000000, r_frame_length};
        end
    end

    mfce_frame #(
        .WORD_COUNT (WORD_COUNT),
        .NRES       (NRES)
    ) u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_end_of_frame (i_end_of_frame),
        .i_frame_length (r_frame_length),
        .i_value_offset (r_value_offset),
        .i_res_free     (res_free),
        .o_done         (done),
        .o_words        (words)
    );

    mfce_emit #(
        .WORD_COUNT (WORD_COUNT),
        .NRES       (NRES)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_done         (done),
        .i_words        (words),
        .o_res_free     (res_free),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_word_value   (o_word_value),
        .o_word_index   (o_word_index),
        .o_frame_status (o_frame_status),
        .o_last_result  (o_last_result)
    );

endmodule

// ===== rtl/core/mfce_frame.sv =====
// ----------------------------------------------------------------------------
// mfce_frame
// Input register, byte counter, CRC register, two-byte delay line and
// word store; produces the frame-end status for the result unit.
// ----------------------------------------------------------------------------
module mfce_frame
    import mfce_pkg::*;
#(
    parameter int WORD_COUNT = WORD_COUNT_DEF,
    parameter int NRES       = (WORD_COUNT < MAX_OUT) ? WORD_COUNT : MAX_OUT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_end_of_frame,
    input  logic [7:0]            i_frame_length,
    input  logic [15:0]           i_value_offset,
    input  logic                  i_res_free,
    output t_done                 o_done,
    output logic [NRES-1:0][15:0] o_words
);

    localparam int MINLEN   = FIRST_WORD_BYTE + 2 * WORD_COUNT + 2;
    localparam int WORD_END = FIRST_WORD_BYTE + 2 * WORD_COUNT;

    logic            r_in_vld;
    logic [7:0]      r_in_byte;
    logic            r_in_eof;
    logic [7:0]      r_count;
    logic [15:0]     r_crc;
    logic [15:0]     r_held;
    logic [7:0]      r_hold;
    logic [15:0]     r_store [NRES];

    logic [7:0]      n_count;
    logic [15:0]     n_crc;
    logic [15:0]     n_held;
    logic [7:0]      n_hold;

    logic            adv;
    logic            proc;
    logic            accept;
    logic [15:0]     crc_upd;
    logic [15:0]     held_upd;
    logic [7:0]      cnt_upd;
    logic [7:0]      rel;
    logic            in_words;
    logic            len_bad;
    logic            crc_bad;

    // A frame-end byte may only move on when the result unit can take it.
    assign adv        = !r_in_eof || i_res_free;
    assign proc       = r_in_vld && adv;
    assign o_in_stall = r_in_vld && !adv;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        crc_upd  = (r_count >= 8'd2) ? crc16_byte(r_crc, r_held[15:8]) : r_crc;
        held_upd = {r_held[7:0], r_in_byte};
        cnt_upd  = (r_count == COUNT_MAX) ? COUNT_MAX : r_count + 8'd1;
        rel      = r_count - 8'(FIRST_WORD_BYTE);
        in_words = (r_count >= 8'(FIRST_WORD_BYTE)) && (r_count < 8'(WORD_END));
        len_bad  = (cnt_upd == COUNT_MAX) || (cnt_upd != i_frame_length)
                   || (cnt_upd < 8'(MINLEN));
        crc_bad  = (held_upd[15:8] != crc_upd[7:0]) || (held_upd[7:0] != crc_upd[15:8]);
    end

    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        n_held  = r_held;
        n_hold  = r_hold;
        if (proc) begin
            if (r_in_eof) begin
                n_count = '0;
                n_crc   = CRC_INIT;
                n_held  = '0;
                n_hold  = '0;
            end else begin
                n_count = cnt_upd;
                n_crc   = crc_upd;
                n_held  = held_upd;
                if (in_words && !rel[0]) begin
                    n_hold = r_in_byte;
                end
            end
        end
    end

    always_comb begin
        o_done.load   = proc && r_in_eof;
        o_done.status = len_bad ? ST_LEN : (crc_bad ? ST_CRC : ST_OK);
        for (int k = 0; k < NRES; k++) begin
            o_words[k] = r_store[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_count  <= '0;
            r_crc    <= CRC_INIT;
            r_held   <= '0;
            r_hold   <= '0;
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end
            r_count <= n_count;
            r_crc   <= n_crc;
            r_held  <= n_held;
            r_hold  <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
            r_in_eof  <= i_end_of_frame;
        end
    end

    // The offset is applied as the low byte of each word comes in.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NRES; k++) begin
            if (proc && in_words && rel[0] && (rel[7:1] == 7'(k))) begin
                r_store[k] <= {r_hold, r_in_byte} - i_value_offset;
            end
        end
    end

endmodule

// ===== rtl/core/mfce_emit.sv =====
// ----------------------------------------------------------------------------
// mfce_emit
// Result register: holds one frame's burst of words or its status result
// and hands them out one transfer at a time.
// ----------------------------------------------------------------------------
module mfce_emit
    import mfce_pkg::*;
#(
    parameter int WORD_COUNT = WORD_COUNT_DEF,
    parameter int NRES       = (WORD_COUNT < MAX_OUT) ? WORD_COUNT : MAX_OUT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_done                 i_done,
    input  logic [NRES-1:0][15:0] i_words,
    output logic                  o_res_free,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_word_value,
    output logic [2:0]            o_word_index,
    output logic [1:0]            o_frame_status,
    output logic                  o_last_result
);

    localparam int CW = $clog2(NRES + 1);

    logic [CW-1:0]         r_cnt;
    logic [2:0]            r_idx;
    t_status               r_status;
    logic [NRES-1:0][15:0] r_buf;

    logic [CW-1:0]         n_cnt;
    logic [2:0]            n_idx;
    t_status               n_status;
    logic [NRES-1:0][15:0] n_buf;

    logic                  take;

    assign take        = o_out_valid && !i_out_stall;
    assign o_out_valid = (r_cnt != '0);
    assign o_res_free  = (r_cnt == '0) || ((r_cnt == CW'(1)) && take);

    assign o_word_value   = r_buf[0];
    assign o_word_index   = r_idx;
    assign o_frame_status = r_status;
    assign o_last_result  = (r_cnt == CW'(1));

    always_comb begin
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_status = r_status;
        n_buf    = r_buf;
        if (i_done.load) begin
            n_idx    = '0;
            n_status = i_done.status;
            if (i_done.status == ST_OK) begin
                n_cnt = CW'(NRES);
                n_buf = i_words;
            end else begin
                n_cnt = CW'(1);
                n_buf = '0;
            end
        end else if (take) begin
            n_cnt = r_cnt - CW'(1);
            n_idx = r_idx + 3'd1;
            for (int k = 0; k < NRES - 1; k++) begin
                n_buf[k] = r_buf[k + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_idx    <= '0;
            r_status <= ST_OK;
        end else begin
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

endmodule

// ===== rtl/core/mfce_checker.sv =====
// ----------------------------------------------------------------------------
// mfce_checker
// Port-level checks on the frame checker's result stream and input stall.
// ----------------------------------------------------------------------------
module mfce_checker
    import mfce_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_word_value,
    input logic [2:0]  o_word_index,
    input logic [1:0]  o_frame_status,
    input logic        o_last_result
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_word_value)
            && $stable(o_word_index) && $stable(o_frame_status)
            && $stable(o_last_result))
        else $error("result changed while stalled");

    // An error result stands alone and carries no word.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_frame_status != ST_OK) |->
            o_last_result && (o_word_value == 16'h0000) && (o_word_index == 3'd0))
        else $error("malformed error result");

    // Words of one frame follow each other with rising index and no gap.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_result |=>
            o_out_valid && (o_frame_status == ST_OK)
            && (o_word_index == $past(o_word_index) + 3'd1))
        else $error("word burst broken");

    // With no result pending, input is never held off.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

endmodule

bind modbus_frame_crc_value_extractor_top mfce_checker u_mfce_checker (.*);
